@@ rtl/bship_pkg.sv @@
// Shared types, constants, register map and control program of the escape-time block.
package bship_pkg;

  localparam int COORD_W   = 12;
  localparam int SIZE_W    = 13;
  localparam int LIMIT_W   = 16;
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 16;
  localparam int SPAN_W    = 33;
  localparam int NUM_W     = 46;
  localparam int QUO_W     = 44;
  localparam int DSTEP_W   = 6;
  localparam int SAT_W     = 66;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int PC_W      = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_REAL_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REAL_HIGH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAG_LOW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAG_HIGH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

  localparam logic [DATA_W-1:0]  RST_REAL_LOW   = 32'hE000_0000;
  localparam logic [DATA_W-1:0]  RST_REAL_HIGH  = 32'h1000_0000;
  localparam logic [DATA_W-1:0]  RST_IMAG_LOW   = 32'hE000_0000;
  localparam logic [DATA_W-1:0]  RST_IMAG_HIGH  = 32'h1000_0000;
  localparam logic [SIZE_W-1:0]  RST_WIDTH      = 13'd1024;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT     = 13'd1024;
  localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd255;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  typedef logic [3:0] op_t;
  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_IDLE    = 4'd1;
  localparam op_t OP_SPAN    = 4'd2;
  localparam op_t OP_SCALE   = 4'd3;
  localparam op_t OP_DIVLD   = 4'd4;
  localparam op_t OP_DIVSTEP = 4'd5;
  localparam op_t OP_SIGN    = 4'd6;
  localparam op_t OP_OFFSET  = 4'd7;
  localparam op_t OP_INIT    = 4'd8;
  localparam op_t OP_MUL_RR  = 4'd9;
  localparam op_t OP_MUL_II  = 4'd10;
  localparam op_t OP_MUL_RI  = 4'd11;
  localparam op_t OP_TEST    = 4'd12;
  localparam op_t OP_UPDATE  = 4'd13;
  localparam op_t OP_DONE    = 4'd14;

  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEXT       = 3'd0;
  localparam cond_t COND_ALWAYS     = 3'd1;
  localparam cond_t COND_DIV_MORE   = 3'd2;
  localparam cond_t COND_LIMIT_ZERO = 3'd3;
  localparam cond_t COND_ESCAPE     = 3'd4;
  localparam cond_t COND_MORE       = 3'd5;

  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_IDLE     = 5'd0;
  localparam pc_t PC_DIV_RE   = 5'd4;
  localparam pc_t PC_DIV_IM   = 5'd10;
  localparam pc_t PC_LOOP     = 5'd14;
  localparam pc_t PC_DONE     = 5'd19;
  localparam pc_t PC_DONE_ESC = 5'd20;
  localparam pc_t PC_LAST     = 5'd20;

  localparam logic AXIS_RE = 1'b0;
  localparam logic AXIS_IM = 1'b1;

  // sel picks the axis for mapping steps and the escaped flag for done steps
  typedef struct packed {
    op_t   op;
    logic  sel;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  function automatic ctrl_t mk_ctrl(input op_t op, input logic sel, input cond_t cond,
                                    input pc_t target);
    ctrl_t w;
    w.op     = op;
    w.sel    = sel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    case (pc)
      5'd0:    w = mk_ctrl(OP_IDLE,    1'b0,    COND_NEXT,       PC_IDLE);
      5'd1:    w = mk_ctrl(OP_SPAN,    AXIS_RE, COND_NEXT,       PC_IDLE);
      5'd2:    w = mk_ctrl(OP_SCALE,   AXIS_RE, COND_NEXT,       PC_IDLE);
      5'd3:    w = mk_ctrl(OP_DIVLD,   AXIS_RE, COND_NEXT,       PC_IDLE);
      5'd4:    w = mk_ctrl(OP_DIVSTEP, AXIS_RE, COND_DIV_MORE,   PC_DIV_RE);
      5'd5:    w = mk_ctrl(OP_SIGN,    AXIS_RE, COND_NEXT,       PC_IDLE);
      5'd6:    w = mk_ctrl(OP_OFFSET,  AXIS_RE, COND_NEXT,       PC_IDLE);
      5'd7:    w = mk_ctrl(OP_SPAN,    AXIS_IM, COND_NEXT,       PC_IDLE);
      5'd8:    w = mk_ctrl(OP_SCALE,   AXIS_IM, COND_NEXT,       PC_IDLE);
      5'd9:    w = mk_ctrl(OP_DIVLD,   AXIS_IM, COND_NEXT,       PC_IDLE);
      5'd10:   w = mk_ctrl(OP_DIVSTEP, AXIS_IM, COND_DIV_MORE,   PC_DIV_IM);
      5'd11:   w = mk_ctrl(OP_SIGN,    AXIS_IM, COND_NEXT,       PC_IDLE);
      5'd12:   w = mk_ctrl(OP_OFFSET,  AXIS_IM, COND_NEXT,       PC_IDLE);
      5'd13:   w = mk_ctrl(OP_INIT,    1'b0,    COND_LIMIT_ZERO, PC_DONE);
      5'd14:   w = mk_ctrl(OP_MUL_RR,  1'b0,    COND_NEXT,       PC_IDLE);
      5'd15:   w = mk_ctrl(OP_MUL_II,  1'b0,    COND_NEXT,       PC_IDLE);
      5'd16:   w = mk_ctrl(OP_MUL_RI,  1'b0,    COND_NEXT,       PC_IDLE);
      5'd17:   w = mk_ctrl(OP_TEST,    1'b0,    COND_ESCAPE,     PC_DONE_ESC);
      5'd18:   w = mk_ctrl(OP_UPDATE,  1'b0,    COND_MORE,       PC_LOOP);
      5'd19:   w = mk_ctrl(OP_DONE,    1'b0,    COND_ALWAYS,     PC_IDLE);
      5'd20:   w = mk_ctrl(OP_DONE,    1'b1,    COND_ALWAYS,     PC_IDLE);
      default: w = mk_ctrl(OP_NOP,     1'b0,    COND_ALWAYS,     PC_IDLE);
    endcase
    return w;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (!v[SAT_W-1] && (v[SAT_W-2:DATA_W-1] != '0)) begin
      r = $signed(S32_MAX);
    end else if (v[SAT_W-1] && !(&v[SAT_W-2:DATA_W-1])) begin
      r = $signed(S32_MIN);
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

@@ rtl/bship_pix_if.sv @@
// Pixel coordinate channel: valid/ready with column and row payload.
interface bship_pix_if;
  logic                           valid;
  logic                           ready;
  logic [bship_pkg::COORD_W-1:0] pixel_column;
  logic [bship_pkg::COORD_W-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

@@ rtl/bship_res_if.sv @@
// Result channel: valid/ready with escape count and escaped flag.
interface bship_res_if;
  logic                             valid;
  logic                             ready;
  logic [bship_pkg::OUT_CNT_W-1:0] escape_count;
  logic                             escaped;

  modport source (output valid, output escape_count, output escaped, input ready);
  modport sink   (input valid, input escape_count, input escaped, output ready);
endinterface

@@ rtl/burning_ship_escape_time.sv @@
// Burning ship escape-time pixel engine: APB registers, microcoded datapath, result register.
// One pixel at a time: a beat on in_pix is mapped into the complex plane (one bit of
// quotient per cycle), then iterated on a single 32x32 multiplier that runs three
// products per iteration. A pixel that runs its full limit without escaping leaves
// after its last update step; one that escapes after N full iterations leaves from the
// escape test of the next iteration. The next pixel is taken as soon as the sequencer
// returns to idle, even while the previous result still waits in the output register.
// Registers sit at byte address 4*index; write them only while the block is idle.
module burning_ship_escape_time #(
  parameter int MAX_DIMENSION = 4096,
  parameter int FRACTION_BITS = 28,
  parameter int COUNT_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bship_pix_if.sink                      in_pix,
  bship_res_if.source                    out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bship_pkg::ADDR_W-1:0]  paddr,
  input  logic [bship_pkg::DATA_W-1:0]  pwdata,
  output logic [bship_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);

  localparam int DIV_W = $clog2(MAX_DIMENSION + 1);
  localparam int SQ_W  = 64 - FRACTION_BITS;
  localparam int RND_W = 65;

  // Configuration registers
  logic [bship_pkg::DATA_W-1:0]  real_low_r, real_high_r, imag_low_r, imag_high_r;
  logic [bship_pkg::SIZE_W-1:0]  width_pixels_r, height_pixels_r;
  logic [bship_pkg::LIMIT_W-1:0] iteration_limit_r;
  logic                          cfg_wr;
  logic [bship_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[bship_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_low_r        <= bship_pkg::RST_REAL_LOW;
      real_high_r       <= bship_pkg::RST_REAL_HIGH;
      imag_low_r        <= bship_pkg::RST_IMAG_LOW;
      imag_high_r       <= bship_pkg::RST_IMAG_HIGH;
      width_pixels_r    <= bship_pkg::RST_WIDTH;
      height_pixels_r   <= bship_pkg::RST_HEIGHT;
      iteration_limit_r <= bship_pkg::RST_ITER_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bship_pkg::REG_REAL_LOW:   real_low_r        <= pwdata;
        bship_pkg::REG_REAL_HIGH:  real_high_r       <= pwdata;
        bship_pkg::REG_IMAG_LOW:   imag_low_r        <= pwdata;
        bship_pkg::REG_IMAG_HIGH:  imag_high_r       <= pwdata;
        bship_pkg::REG_WIDTH:      width_pixels_r    <= pwdata[bship_pkg::SIZE_W-1:0];
        bship_pkg::REG_HEIGHT:     height_pixels_r   <= pwdata[bship_pkg::SIZE_W-1:0];
        bship_pkg::REG_ITER_LIMIT: iteration_limit_r <= pwdata[bship_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bship_pkg::REG_REAL_LOW:   prdata = real_low_r;
      bship_pkg::REG_REAL_HIGH:  prdata = real_high_r;
      bship_pkg::REG_IMAG_LOW:   prdata = imag_low_r;
      bship_pkg::REG_IMAG_HIGH:  prdata = imag_high_r;
      bship_pkg::REG_WIDTH:      prdata = bship_pkg::DATA_W'(width_pixels_r);
      bship_pkg::REG_HEIGHT:     prdata = bship_pkg::DATA_W'(height_pixels_r);
      bship_pkg::REG_ITER_LIMIT: prdata = bship_pkg::DATA_W'(iteration_limit_r);
      default:                   prdata = '0;
    endcase
  end

  // Sequencer
  bship_pkg::pc_t   pc_r, pc_nxt;
  bship_pkg::ctrl_t cw;
  logic             in_fire, out_free, hold, take, done_fire;

  // Datapath registers
  logic [bship_pkg::COORD_W-1:0]       col_r, col_nxt, row_r, row_nxt;
  logic signed [bship_pkg::SPAN_W-1:0] span_r, span_nxt;
  logic [DIV_W-1:0]                    div_r, div_nxt, rem_r, rem_nxt;
  logic signed [bship_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [bship_pkg::QUO_W-1:0]         dq_r, dq_nxt;
  logic                                neg_r, neg_nxt;
  logic [bship_pkg::DSTEP_W-1:0]       dstep_r, dstep_nxt;
  logic signed [bship_pkg::DATA_W-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [bship_pkg::DATA_W-1:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic [bship_pkg::DATA_W-1:0]        ar_r, ar_nxt, ai_r, ai_nxt;
  logic [63:0]                         prod_r, prod_nxt;
  logic [SQ_W-1:0]                     sr_r, sr_nxt, si_r, si_nxt, cross_r, cross_nxt;
  logic [COUNT_BITS-1:0]               count_r, count_nxt, limit_r, limit_nxt;
  logic                                out_valid_r, out_valid_nxt, out_esc_r, out_esc_nxt;
  logic [bship_pkg::OUT_CNT_W-1:0]     out_count_r, out_count_nxt;

  // Combinational helpers
  logic [bship_pkg::DATA_W-1:0]        lo_sel, hi_sel;
  logic [bship_pkg::SIZE_W-1:0]        size_sel;
  logic [bship_pkg::COORD_W-1:0]       coord_sel;
  logic [31:0]                         size_ext, size_clamp;
  logic signed [bship_pkg::NUM_W-1:0]  num_mag, quo_ext;
  logic [DIV_W:0]                      trial;
  logic                                trial_ge;
  logic signed [bship_pkg::SAT_W-1:0]  off_sum, zr_wide, zi_wide;
  logic [bship_pkg::DATA_W-1:0]        mul_a, mul_b;
  logic [63:0]                         mul_p;
  logic [RND_W-1:0]                    rnd_sq, rnd_cr;
  logic [SQ_W:0]                       mag_sum;
  logic                                esc_hit;
  logic [32:0]                         lim_ext, cnt_max, lim_clip_w;
  logic [COUNT_BITS-1:0]               limit_clip, count_inc;

  assign cw           = bship_pkg::ucode(pc_r);
  assign in_pix.ready = (cw.op == bship_pkg::OP_IDLE);
  assign in_fire      = in_pix.valid && in_pix.ready;
  assign out_free     = !out_valid_r || out_res.ready;
  assign hold         = ((cw.op == bship_pkg::OP_IDLE) && !in_pix.valid) ||
                        ((cw.op == bship_pkg::OP_DONE) && !out_free);
  assign done_fire    = (cw.op == bship_pkg::OP_DONE) && out_free;

  // Axis selection for the mapping steps
  assign lo_sel    = cw.sel ? imag_low_r  : real_low_r;
  assign hi_sel    = cw.sel ? imag_high_r : real_high_r;
  assign size_sel  = cw.sel ? height_pixels_r : width_pixels_r;
  assign coord_sel = cw.sel ? row_r : col_r;
  assign size_ext  = 32'(size_sel);

  always_comb begin
    if (size_ext == 32'd0) begin
      size_clamp = 32'd1;
    end else if (size_ext > 32'(MAX_DIMENSION)) begin
      size_clamp = 32'(MAX_DIMENSION);
    end else begin
      size_clamp = size_ext;
    end
  end

  assign num_mag  = num_r[bship_pkg::NUM_W-1] ? -num_r : num_r;
  assign quo_ext  = $signed(bship_pkg::NUM_W'(dq_r));
  assign trial    = {rem_r, dq_r[bship_pkg::QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, div_r});
  assign off_sum  = $signed(bship_pkg::SAT_W'(num_r)) +
                    $signed(bship_pkg::SAT_W'($signed(lo_sel)));

  // Shared multiplier: |zr|^2, |zi|^2, |zr|*|zi|
  assign mul_a = (cw.op == bship_pkg::OP_MUL_II) ? ai_r : ar_r;
  assign mul_b = (cw.op == bship_pkg::OP_MUL_RR) ? ar_r : ai_r;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Round half up to FRACTION_BITS; the cross term carries the factor of two
  assign rnd_sq  = {1'b0, prod_r} + (RND_W'(1) << (FRACTION_BITS - 1));
  assign rnd_cr  = {prod_r, 1'b0} + (RND_W'(1) << (FRACTION_BITS - 1));
  assign mag_sum = {1'b0, sr_r} + {1'b0, si_r};
  assign esc_hit = (bship_pkg::SAT_W'(mag_sum) >= (bship_pkg::SAT_W'(1) << (FRACTION_BITS + 2)));
  assign zr_wide = $signed(bship_pkg::SAT_W'(sr_r)) - $signed(bship_pkg::SAT_W'(si_r)) +
                   $signed(bship_pkg::SAT_W'(cr_r));
  assign zi_wide = $signed(bship_pkg::SAT_W'(cross_r)) + $signed(bship_pkg::SAT_W'(ci_r));

  assign lim_ext    = 33'(iteration_limit_r);
  assign cnt_max    = (33'(1) << COUNT_BITS) - 33'(1);
  assign lim_clip_w = (lim_ext > cnt_max) ? cnt_max : lim_ext;
  assign limit_clip = lim_clip_w[COUNT_BITS-1:0];
  assign count_inc  = count_r + COUNT_BITS'(1);

  always_comb begin
    case (cw.cond)
      bship_pkg::COND_NEXT:       take = 1'b0;
      bship_pkg::COND_ALWAYS:     take = 1'b1;
      bship_pkg::COND_DIV_MORE:   take = (dstep_r != bship_pkg::DSTEP_W'(1));
      bship_pkg::COND_LIMIT_ZERO: take = (limit_clip == '0);
      bship_pkg::COND_ESCAPE:     take = esc_hit;
      bship_pkg::COND_MORE:       take = (count_inc != limit_r);
      default:                    take = 1'b0;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + bship_pkg::PC_W'(1);
    end
  end

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    span_nxt      = span_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    dq_nxt        = dq_r;
    neg_nxt       = neg_r;
    dstep_nxt     = dstep_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    ar_nxt        = ar_r;
    ai_nxt        = ai_r;
    prod_nxt      = prod_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    cross_nxt     = cross_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    out_count_nxt = out_count_r;
    out_esc_nxt   = out_esc_r;
    out_valid_nxt = out_valid_r && !out_res.ready;

    case (cw.op)
      bship_pkg::OP_IDLE: begin
        if (in_fire) begin
          col_nxt = in_pix.pixel_column;
          row_nxt = in_pix.pixel_row;
        end
      end
      bship_pkg::OP_SPAN: begin
        span_nxt = $signed({hi_sel[bship_pkg::DATA_W-1], hi_sel}) -
                   $signed({lo_sel[bship_pkg::DATA_W-1], lo_sel});
        div_nxt  = size_clamp[DIV_W-1:0];
      end
      bship_pkg::OP_SCALE: begin
        num_nxt = bship_pkg::NUM_W'($signed({1'b0, coord_sel})) *
                  bship_pkg::NUM_W'(span_r);
      end
      bship_pkg::OP_DIVLD: begin
        dq_nxt    = num_mag[bship_pkg::QUO_W-1:0];
        neg_nxt   = num_r[bship_pkg::NUM_W-1];
        rem_nxt   = '0;
        dstep_nxt = bship_pkg::DSTEP_W'(bship_pkg::QUO_W);
      end
      bship_pkg::OP_DIVSTEP: begin
        // restoring step: shift in one dividend bit, subtract when it fits
        rem_nxt   = trial_ge ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
        dq_nxt    = {dq_r[bship_pkg::QUO_W-2:0], trial_ge};
        dstep_nxt = dstep_r - bship_pkg::DSTEP_W'(1);
      end
      bship_pkg::OP_SIGN: begin
        num_nxt = neg_r ? -quo_ext : quo_ext;
      end
      bship_pkg::OP_OFFSET: begin
        if (cw.sel) begin
          ci_nxt = bship_pkg::sat32(off_sum);
        end else begin
          cr_nxt = bship_pkg::sat32(off_sum);
        end
      end
      bship_pkg::OP_INIT: begin
        zr_nxt    = '0;
        zi_nxt    = '0;
        ar_nxt    = '0;
        count_nxt = '0;
        limit_nxt = limit_clip;
      end
      bship_pkg::OP_MUL_RR: begin
        prod_nxt = mul_p;
        ai_nxt   = bship_pkg::abs32(zi_r);
      end
      bship_pkg::OP_MUL_II: begin
        prod_nxt = mul_p;
        sr_nxt   = rnd_sq[FRACTION_BITS +: SQ_W];
      end
      bship_pkg::OP_MUL_RI: begin
        prod_nxt = mul_p;
        si_nxt   = rnd_sq[FRACTION_BITS +: SQ_W];
      end
      bship_pkg::OP_TEST: begin
        // zr is free to advance here: on escape it is no longer needed
        zr_nxt    = bship_pkg::sat32(zr_wide);
        cross_nxt = rnd_cr[FRACTION_BITS +: SQ_W];
      end
      bship_pkg::OP_UPDATE: begin
        zi_nxt    = bship_pkg::sat32(zi_wide);
        ar_nxt    = bship_pkg::abs32(zr_r);
        count_nxt = count_inc;
      end
      bship_pkg::OP_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = bship_pkg::OUT_CNT_W'(count_r);
          out_esc_nxt   = cw.sel;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= bship_pkg::PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    span_r      <= span_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    num_r       <= num_nxt;
    dq_r        <= dq_nxt;
    neg_r       <= neg_nxt;
    dstep_r     <= dstep_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    ar_r        <= ar_nxt;
    ai_r        <= ai_nxt;
    prod_r      <= prod_nxt;
    sr_r        <= sr_nxt;
    si_r        <= si_nxt;
    cross_r     <= cross_nxt;
    count_r     <= count_nxt;
    limit_r     <= limit_nxt;
    out_count_r <= out_count_nxt;
    out_esc_r   <= out_esc_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.escape_count = out_count_r;
  assign out_res.escaped      = out_esc_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == bship_pkg::OP_DIVSTEP) |=> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_escape_before_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && cw.sel) |-> (count_r < limit_r))
    else $error("escape reported at or beyond the iteration limit");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && !cw.sel) |-> (count_r == limit_r))
    else $error("non-escaped result without reaching the limit");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done_fire))
    else $error("result beat raised outside a done step");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= bship_pkg::PC_LAST)
    else $error("step counter outside the program");

endmodule
